// ===== rtl/core/doy_pkg.sv =====
// Shared types and tables for the day-of-year to date converter.
// Holds the stage payload structs and the month start table.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package doy_pkg;

    localparam int unsigned NumMonths = 12;
    localparam logic [6:0]  LastYear  = 7'd99;
    localparam logic [8:0]  LenCommon = 9'd365;
    localparam logic [8:0]  LenLeap   = 9'd366;

    // Payload after the range check and the weekday sum.
    typedef struct packed {
        logic       err;
        logic       leap;
        logic [8:0] yday;
        logic [8:0] wsum;
    } t_chk;

    // Payload after the month search and the weekday reduction.
    typedef struct packed {
        logic       err;
        logic       leap;
        logic [8:0] yday;
        logic [3:0] month;
        logic [2:0] wday;
    } t_mon;

    // Final result item.
    typedef struct packed {
        logic       err;
        logic [3:0] month;
        logic [4:0] mday;
        logic [2:0] wday;
    } t_res;

    // Days before the first of the given month; a leap year adds one from March on.
    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        case (month)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (month >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/doy_check.sv =====
// First stage: range check of year and day, leap flag and weekday sum.
// Depends on doy_pkg.
`default_nettype none

module doy_check import doy_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_valid,
    input  wire [6:0]  i_year,
    input  wire [8:0]  i_yday,
    output logic       o_valid,
    output t_chk       o_data
);

    logic       r_valid;
    t_chk       r_data;
    t_chk       n_data;
    logic       year_ok;
    logic       day_ok;
    logic       leap;
    logic [6:0] leaps_before;

    always_comb begin
        year_ok = (i_year <= LastYear);
        // Within 1900..1999 only 1900 breaks the every-fourth-year rule.
        leap    = (i_year[1:0] == 2'b00) && (i_year != 7'd0);
        day_ok  = (i_yday != 9'd0) && (i_yday <= (leap ? LenLeap : LenCommon));
        leaps_before = (i_year == 7'd0) ? 7'd0 : ((i_year - 7'd1) >> 2);
        n_data.err  = !(year_ok && day_ok);
        n_data.leap = leap;
        n_data.yday = i_yday;
        // 365 is 1 mod 7 and the epoch offset is a multiple of 7, so the
        // weekday is this sum mod 7.
        n_data.wsum = i_yday + {2'b00, i_year} + {2'b00, leaps_before};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/doy_month.sv =====
// Second stage: month search against the month start table and weekday mod 7.
// Depends on doy_pkg.
`default_nettype none

module doy_month import doy_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_valid,
    input  t_chk       i_data,
    output logic       o_valid,
    output t_mon       o_data
);

    logic       r_valid;
    t_mon       r_data;
    t_mon       n_data;
    logic [3:0] cnt;
    logic [4:0] digit_sum;
    logic [3:0] folded;

    always_comb begin
        cnt = 4'd0;
        for (int m = 1; m < NumMonths; m++) begin
            if (i_data.yday > month_start(4'(m), i_data.leap)) begin
                cnt = cnt + 4'd1;
            end
        end
        // 8 is 1 mod 7, so octal digits can be summed and folded again.
        digit_sum = {2'b00, i_data.wsum[2:0]} + {2'b00, i_data.wsum[5:3]}
                  + {2'b00, i_data.wsum[8:6]};
        folded    = {2'b00, digit_sum[4:3]} + {1'b0, digit_sum[2:0]};
        n_data.err   = i_data.err;
        n_data.leap  = i_data.leap;
        n_data.yday  = i_data.yday;
        n_data.month = cnt;
        n_data.wday  = (folded >= 4'd7) ? 3'(folded - 4'd7) : folded[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/doy_result.sv =====
// Third stage: day of the month and the output register with error zeroing.
// Depends on doy_pkg.
`default_nettype none

module doy_result import doy_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_valid,
    input  t_mon       i_data,
    output logic       o_valid,
    output t_res       o_data
);

    logic       r_valid;
    t_res       r_data;
    t_res       n_data;
    logic [8:0] mday_full;

    always_comb begin
        mday_full = i_data.yday - month_start(i_data.month, i_data.leap);
        if (i_data.err) begin
            n_data = '0;
            n_data.err = 1'b1;
        end else begin
            n_data.err   = 1'b0;
            n_data.month = i_data.month;
            n_data.mday  = mday_full[4:0];
            n_data.wday  = i_data.wday;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/day_of_year_to_date.sv =====
// Top level of the day-of-year to date converter: three pipeline stages.
// Depends on doy_pkg, doy_check, doy_month and doy_result.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: year_of_century[6:0], day_of_year[15:7]
//  m_axis    out        tdata: month_index[3:0], day_of_month[8:4], weekday[11:9]
//                       tuser: range_error[0]
//
// One item enters per cycle while a stage is free or the output takes a result.
// An item moves through the check, month and result registers, in that order.
// The three pipeline registers set the latency; each stage holds one item.
// Reset clears the stage valid bits; payload registers are not reset.
// A stage loads whenever it is empty or its successor loads, so bubbles are
// squeezed out and input is taken while a finished result waits and a stage is free.
`default_nettype none

module day_of_year_to_date import doy_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // year_of_century[6:0], day_of_year[15:7]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // month_index, day_of_month, weekday, zero pad
    output logic [0:0]  m_axis_tuser    // range_error
);

    logic en1, en2, en3;
    logic v1, v2, v3;
    t_chk d1;
    t_mon d2;
    t_res d3;

    assign en3 = !v3 || m_axis_tready;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;
    assign s_axis_tready = en1;

    doy_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (s_axis_tvalid),
        .i_year  (s_axis_tdata[6:0]),
        .i_yday  (s_axis_tdata[15:7]),
        .o_valid (v1),
        .o_data  (d1)
    );

    doy_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (v1),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    doy_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (v2),
        .i_data  (d2),
        .o_valid (v3),
        .o_data  (d3)
    );

    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = {4'b0000, d3.wday, d3.mday, d3.month};
    assign m_axis_tuser  = d3.err;

    // Input is refused only when every stage holds an item.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (v1 && v2 && v3))
        else $error("input stalled while the pipeline has a free stage");

    // An error result carries zero in every other field.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("error result with nonzero fields");

    // A good result has a real month, a nonzero day and a weekday below seven.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            ((m_axis_tdata[3:0] <= 4'd11) && (m_axis_tdata[8:4] != 5'd0)
             && (m_axis_tdata[11:9] != 3'd7)))
        else $error("good result out of range");

    // An accepted item sits in the first stage after the edge that takes it.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1)
        else $error("accepted item lost in the first stage");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for day_of_year_to_date. It sends directed and random dates into the stream
// input, predicts each converted date and checks it field by field on the stream output.
// Depends on doy_pkg and the day_of_year_to_date RTL only.

module tb;
    import doy_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int LongHold   = 160;
    localparam int WeekBias   = 7340035 - 25567;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // year_of_century[6:0], day_of_year[15:7]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // month_index[3:0], day_of_month[8:4], weekday[11:9]
    logic [0:0]  m_axis_tuser;          // range_error[0]

    t_res dates_due[$];
    int   mismatches   = 0;
    int   cycle_count  = 0;
    int   send_gap_max = 6;
    int   take_gap_max = 6;
    int   take_wait    = 0;
    logic take_hold    = 1'b0;
    event hold_request;

    day_of_year_to_date uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit leap_year(input int yoc);
        int full;
        full = yoc + 1900;
        return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
    endfunction

    function automatic t_res predict_date(input logic [6:0] yoc, input logic [8:0] yday);
        int   month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        t_res r;
        bit   leap;
        int   rest;
        int   mon;
        int   days;
        int   y;
        r    = '0;
        leap = leap_year(int'(yoc));
        if (yoc > LastYear || yday == 9'd0 || yday > (leap ? LenLeap : LenCommon)) begin
            r.err = 1'b1;
            return r;
        end
        if (leap) begin
            month_len[1] = 29;
        end
        rest = int'(yday);
        mon  = 0;
        while (mon < 11 && rest > month_len[mon]) begin
            rest -= month_len[mon];
            mon++;
        end
        // Day count from the first of January 1900, one-based.
        days = int'(yday);
        for (y = 0; y < int'(yoc); y++) begin
            days += leap_year(y) ? int'(LenLeap) : int'(LenCommon);
        end
        r.month = 4'(mon);
        r.mday  = 5'(rest);
        r.wday  = 3'((days + WeekBias) % 7);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (dates_due.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with no item outstanding",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = dates_due.pop_front();
                check_field("range_error", 8'(m_axis_tuser[0]), 8'(want.err));
                check_field("month_index", 8'(m_axis_tdata[3:0]), 8'(want.month));
                check_field("day_of_month", 8'(m_axis_tdata[8:4]), 8'(want.mday));
                check_field("weekday", 8'(m_axis_tdata[11:9]), 8'(want.wday));
            end
        end
    end

    // Output side: a random wait after every item taken, overridden by a long hold.
    always @(posedge i_clk) begin : result_sink
        int gap;
        if (take_hold) begin
            m_axis_tready <= 1'b0;
        end else if (take_wait > 0) begin
            take_wait <= take_wait - 1;
        end else if (!m_axis_tready) begin
            m_axis_tready <= 1'b1;
        end else if (m_axis_tvalid === 1'b1) begin
            gap = $urandom_range(0, take_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                take_wait     <= gap - 1;
            end
        end
    end

    initial begin : hold_counter
        forever begin
            @(hold_request);
            take_hold <= 1'b1;
            repeat (LongHold) @(posedge i_clk);
            take_hold <= 1'b0;
        end
    end

    // Valid stays high from one item to the next unless a gap is drawn.
    task automatic send_item(input logic [6:0] yoc, input logic [8:0] yday);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yday, yoc};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        dates_due.push_back(predict_date(yoc, yday));
    endtask

    task automatic send_random_date();
        logic [6:0] yoc;
        logic [8:0] yday;
        int         pick;
        int         len;
        pick = $urandom_range(0, 9);
        yoc  = 7'($urandom_range(0, 99));
        len  = leap_year(int'(yoc)) ? int'(LenLeap) : int'(LenCommon);
        if (pick < 7) begin
            yday = 9'($urandom_range(1, len));
        end else if (pick < 9) begin
            case ($urandom_range(0, 5))
                0:       yday = 9'd0;
                1:       yday = 9'd1;
                2:       yday = 9'(len);
                3:       yday = 9'(len + 1);
                4:       yday = LenLeap;
                default: yday = 9'($urandom_range(58, 61));
            endcase
        end else begin
            {yday, yoc} = 16'($urandom);
        end
        send_item(yoc, yday);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (dates_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [6:0] years[24] = '{0, 0, 0, 0, 0, 0, 4, 4, 4, 70, 70, 99,
                                  99, 99, 96, 100, 127, 127, 0, 64, 64, 64, 1, 50};
        logic [8:0] ydays[24] = '{1, 365, 366, 0, 59, 60, 60, 366, 367, 1, 365, 1,
                                  365, 366, 366, 1, 511, 0, 511, 31, 32, 335, 334, 32};
        int i;
        for (i = 0; i < 24; i++) begin
            send_item(years[i], ydays[i]);
        end
    endtask

    task automatic test_random_dates();
        int chunk;
        int i;
        for (chunk = 0; chunk < 15; chunk++) begin
            send_gap_max = (chunk % 3 == 0) ? 0 : 6;
            take_gap_max <= (chunk % 4 == 1) ? 0 : 6;
            for (i = 0; i < 60; i++) begin
                send_random_date();
            end
        end
        take_gap_max <= 6;
        send_gap_max = 6;
    endtask

    // The output holds off long enough for the pipeline to fill and stall the input.
    task automatic test_output_hold();
        int i;
        send_gap_max = 0;
        -> hold_request;
        for (i = 0; i < 80; i++) begin
            send_random_date();
        end
        send_gap_max = 6;
        drain_results();
    endtask

    task automatic test_paused_bursts();
        int burst;
        int i;
        for (burst = 0; burst < 3; burst++) begin
            for (i = 0; i < 20; i++) begin
                send_random_date();
            end
            drain_results();
        end
    endtask

    initial begin : run
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_dates();
        test_output_hold();
        test_paused_bursts();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/doy_pkg.sv
rtl/core/doy_check.sv
rtl/core/doy_month.sv
rtl/core/doy_result.sv
rtl/core/day_of_year_to_date.sv
test/tb.sv
